// File: src/hsl_to_rgb_converter_assert.svh
// Assertion helpers used by the checker file.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define HSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked on every clock edge, reset included.
`define HSL_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: src/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS    = 12;
  localparam int HUE_SUB_BITS = 6;

  // Port field widths
  localparam int HUE_W  = 15;
  localparam int OFFS_W = 16;
  localparam int FRAC_W = 13;
  localparam int CHAN_W = 8;

  localparam int ONE_FRAC     = 1 << FRAC_BITS;
  localparam int SECTOR_UNITS = 60 << HUE_SUB_BITS;
  localparam int TURN_UNITS   = 6 * SECTOR_UNITS;
  localparam int NUM_SECTORS  = 6;
  localparam int SECTOR_W     = 3;

  // Biased hue sum: hue + offset + two turns, always positive
  localparam int BIAS_W   = HUE_W + 2;
  localparam int HUE_BIAS = 2 * TURN_UNITS;

  // Intermediate widths
  localparam int TRI_W = $clog2(SECTOR_UNITS + 1);
  localparam int LF_W  = FRAC_BITS + 1;
  localparam int C_W   = 2 * FRAC_BITS + 1;
  localparam int D_W   = 2 * FRAC_BITS + 2;
  localparam int P_W   = C_W + TRI_W;
  localparam int Y_W   = D_W + TRI_W + 1;

  // 255 / (2^(2F+1) * 60 * 2^HSB) == 17 / 2^(2F+HSB+3)
  localparam int SCALE_MUL   = 17;
  localparam int SCALE_SHIFT = 2 * FRAC_BITS + HUE_SUB_BITS + 3;
  localparam int CHAN_MAX    = 255;

  // Which component lands on a channel
  typedef enum logic [1:0] {
    SLOT_CHROMA,
    SLOT_SECOND,
    SLOT_ZERO
  } slot_t;

  typedef struct packed {
    slot_t red;
    slot_t green;
    slot_t blue;
  } arrange_t;

  typedef logic [Y_W-1:0] level_t;

  // Channel arrangement per 60-degree sector
  function automatic arrange_t sector_arrange(input logic [SECTOR_W-1:0] sector);
    arrange_t arr;
    case (sector)
      3'd0:    arr = '{SLOT_CHROMA, SLOT_SECOND, SLOT_ZERO};
      3'd1:    arr = '{SLOT_SECOND, SLOT_CHROMA, SLOT_ZERO};
      3'd2:    arr = '{SLOT_ZERO, SLOT_CHROMA, SLOT_SECOND};
      3'd3:    arr = '{SLOT_ZERO, SLOT_SECOND, SLOT_CHROMA};
      3'd4:    arr = '{SLOT_SECOND, SLOT_ZERO, SLOT_CHROMA};
      default: arr = '{SLOT_CHROMA, SLOT_ZERO, SLOT_SECOND};
    endcase
    return arr;
  endfunction

endpackage

// File: src/hsl2rgb_scale.sv
// Converts a channel level (scaled by 2^(2F+1) * sector width) to 0..255.
module hsl2rgb_scale
  import hsl2rgb_pkg::*;
(
  input  level_t            level,
  output logic [CHAN_W-1:0] chan
);

  localparam int PROD_W = Y_W + 5;
  localparam int VAL_W  = PROD_W - SCALE_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  val;

  // level * 17, then drop the fraction
  assign prod = PROD_W'(level) * PROD_W'(SCALE_MUL);
  assign val  = prod[PROD_W-1:SCALE_SHIFT];

  // Exactly 1.0 already gives 255; clamp guards the top code
  assign chan = (val > VAL_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : val[CHAN_W-1:0];

endmodule

// File: src/hsl_to_rgb_converter.sv
// HSLA to RGBA color converter. Hue is in 1/64 degree units and is offset by a
// signed hue_offset, then wrapped into one turn; saturation, luminance and
// opacity carry 12 fraction bits (4096 is 1.0, larger values clamp to 1.0).
// Each channel is the exact HSL result times 255, truncated. The block takes
// one beat per clock while in_stall is low and passes it through the six
// register stages of the datapath (input, hue wrap, sector/chroma,
// hue-triangle multiply, level sums, output); the input stage loads at the
// accepting edge. Each stage holds its beat only while everything ahead of it
// is full and out_stall is high, so bubbles squeeze out and a stall loses or
// repeats nothing.
module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [HUE_W-1:0]         in_hue,
  input  logic signed [OFFS_W-1:0] in_hue_offset,
  input  logic [FRAC_W-1:0]        in_saturation,
  input  logic [FRAC_W-1:0]        in_luminance,
  input  logic [FRAC_W-1:0]        in_opacity,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CHAN_W-1:0]        out_red,
  output logic [CHAN_W-1:0]        out_green,
  output logic [CHAN_W-1:0]        out_blue,
  output logic [CHAN_W-1:0]        out_alpha_out
);

  localparam int ALPHA_PROD_W = FRAC_W + CHAN_W;

  function automatic logic [FRAC_W-1:0] sat_frac(input logic [FRAC_W-1:0] v);
    return (v > FRAC_W'(ONE_FRAC)) ? FRAC_W'(ONE_FRAC) : v;
  endfunction

  function automatic logic [CHAN_W-1:0] pick(input slot_t slot,
                                             input logic [CHAN_W-1:0] vc,
                                             input logic [CHAN_W-1:0] vx,
                                             input logic [CHAN_W-1:0] vz);
    logic [CHAN_W-1:0] v;
    case (slot)
      SLOT_CHROMA: v = vc;
      SLOT_SECOND: v = vx;
      default:     v = vz;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------- flow control
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !out_valid_r || !out_stall;
  assign rdy5 = !s5_valid_r || rdy6;
  assign rdy4 = !s4_valid_r || rdy5;
  assign rdy3 = !s3_valid_r || rdy4;
  assign rdy2 = !s2_valid_r || rdy3;
  assign rdy1 = !s1_valid_r || rdy2;

  assign in_stall  = !rdy1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r  <= in_valid;
      if (rdy2) s2_valid_r  <= s1_valid_r;
      if (rdy3) s3_valid_r  <= s2_valid_r;
      if (rdy4) s4_valid_r  <= s3_valid_r;
      if (rdy5) s5_valid_r  <= s4_valid_r;
      if (rdy6) out_valid_r <= s5_valid_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Biased hue sum (mod 2^BIAS_W arithmetic lands positive), clamp fractions
  logic [BIAS_W-1:0] s1_bias_r, s1_bias_nxt;
  logic [FRAC_W-1:0] s1_sat_r, s1_lum_r, s1_opa_r;

  assign s1_bias_nxt = BIAS_W'(in_hue) + BIAS_W'(in_hue_offset) + BIAS_W'(HUE_BIAS);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_bias_r <= s1_bias_nxt;
      s1_sat_r  <= sat_frac(in_saturation);
      s1_lum_r  <= sat_frac(in_luminance);
      s1_opa_r  <= sat_frac(in_opacity);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Wrap hue into one turn; 1 - |2L - 1|; alpha scaling
  logic [HUE_W-1:0]        s2_hue_r, s2_hue_nxt;
  logic [LF_W-1:0]         s2_lf_r, s2_lf_nxt;
  logic [FRAC_W-1:0]       s2_sat_r, s2_lum_r;
  logic [CHAN_W-1:0]       s2_alpha_r, s2_alpha_nxt;
  logic [FRAC_W:0]         lum2;
  logic [ALPHA_PROD_W-1:0] alpha_prod;
  logic [ALPHA_PROD_W-FRAC_BITS-1:0] alpha_val;

  always_comb begin
    if (s1_bias_r >= BIAS_W'(4 * TURN_UNITS)) begin
      s2_hue_nxt = HUE_W'(s1_bias_r - BIAS_W'(4 * TURN_UNITS));
    end else if (s1_bias_r >= BIAS_W'(3 * TURN_UNITS)) begin
      s2_hue_nxt = HUE_W'(s1_bias_r - BIAS_W'(3 * TURN_UNITS));
    end else if (s1_bias_r >= BIAS_W'(2 * TURN_UNITS)) begin
      s2_hue_nxt = HUE_W'(s1_bias_r - BIAS_W'(2 * TURN_UNITS));
    end else if (s1_bias_r >= BIAS_W'(TURN_UNITS)) begin
      s2_hue_nxt = HUE_W'(s1_bias_r - BIAS_W'(TURN_UNITS));
    end else begin
      s2_hue_nxt = HUE_W'(s1_bias_r);
    end
  end

  assign lum2 = {s1_lum_r, 1'b0};
  assign s2_lf_nxt = (s1_lum_r <= FRAC_W'(ONE_FRAC / 2)) ? LF_W'(lum2)
                                                         : LF_W'((FRAC_W+1)'(2 * ONE_FRAC) - lum2);

  assign alpha_prod   = ALPHA_PROD_W'(s1_opa_r) * ALPHA_PROD_W'(CHAN_MAX);
  assign alpha_val    = alpha_prod[ALPHA_PROD_W-1:FRAC_BITS];
  assign s2_alpha_nxt = (alpha_val > (ALPHA_PROD_W-FRAC_BITS)'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX)
                                                                       : alpha_val[CHAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_hue_r   <= s2_hue_nxt;
      s2_lf_r    <= s2_lf_nxt;
      s2_sat_r   <= s1_sat_r;
      s2_lum_r   <= s1_lum_r;
      s2_alpha_r <= s2_alpha_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Sector, hue triangle within the double sector, chroma
  logic [SECTOR_W-1:0] s3_sector_r, s3_sector_nxt;
  logic [TRI_W-1:0]    s3_tri_r, s3_tri_nxt;
  logic [C_W-1:0]      s3_chroma_r, s3_chroma_nxt;
  logic [FRAC_W-1:0]   s3_lum_r;
  logic [CHAN_W-1:0]   s3_alpha_r;
  logic [HUE_W-1:0]    sec_base;
  logic [TRI_W-1:0]    sec_rem;

  always_comb begin
    if (s2_hue_r >= HUE_W'(5 * SECTOR_UNITS)) begin
      s3_sector_nxt = SECTOR_W'(5);
      sec_base      = HUE_W'(5 * SECTOR_UNITS);
    end else if (s2_hue_r >= HUE_W'(4 * SECTOR_UNITS)) begin
      s3_sector_nxt = SECTOR_W'(4);
      sec_base      = HUE_W'(4 * SECTOR_UNITS);
    end else if (s2_hue_r >= HUE_W'(3 * SECTOR_UNITS)) begin
      s3_sector_nxt = SECTOR_W'(3);
      sec_base      = HUE_W'(3 * SECTOR_UNITS);
    end else if (s2_hue_r >= HUE_W'(2 * SECTOR_UNITS)) begin
      s3_sector_nxt = SECTOR_W'(2);
      sec_base      = HUE_W'(2 * SECTOR_UNITS);
    end else if (s2_hue_r >= HUE_W'(SECTOR_UNITS)) begin
      s3_sector_nxt = SECTOR_W'(1);
      sec_base      = HUE_W'(SECTOR_UNITS);
    end else begin
      s3_sector_nxt = SECTOR_W'(0);
      sec_base      = '0;
    end
  end

  // Rising edge in even sectors, falling in odd ones
  assign sec_rem       = TRI_W'(s2_hue_r - sec_base);
  assign s3_tri_nxt    = s3_sector_nxt[0] ? TRI_W'(SECTOR_UNITS) - sec_rem : sec_rem;
  assign s3_chroma_nxt = C_W'((2 * LF_W)'(s2_lf_r) * (2 * LF_W)'(s2_sat_r));

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_sector_r <= s3_sector_nxt;
      s3_tri_r    <= s3_tri_nxt;
      s3_chroma_r <= s3_chroma_nxt;
      s3_lum_r    <= s2_lum_r;
      s3_alpha_r  <= s2_alpha_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Chroma times triangle; d = 2L - C (both scaled by 2^(2F))
  logic [P_W-1:0]      s4_prod_r, s4_prod_nxt;
  logic [D_W-1:0]      s4_dif_r, s4_dif_nxt;
  logic [C_W-1:0]      s4_chroma_r;
  logic [SECTOR_W-1:0] s4_sector_r;
  logic [CHAN_W-1:0]   s4_alpha_r;

  assign s4_prod_nxt = P_W'(s3_chroma_r) * P_W'(s3_tri_r);
  assign s4_dif_nxt  = (D_W'(s3_lum_r) << (FRAC_BITS + 1)) - D_W'(s3_chroma_r);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_prod_r   <= s4_prod_nxt;
      s4_dif_r    <= s4_dif_nxt;
      s4_chroma_r <= s3_chroma_r;
      s4_sector_r <= s3_sector_r;
      s4_alpha_r  <= s3_alpha_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Component + m over the common denominator 2^(2F+1) * sector width
  level_t              s5_yc_r, s5_yx_r, s5_yz_r;
  level_t              s5_yc_nxt, s5_yx_nxt, s5_yz_nxt;
  logic [SECTOR_W-1:0] s5_sector_r;
  logic [CHAN_W-1:0]   s5_alpha_r;

  assign s5_yz_nxt = Y_W'(s4_dif_r) * Y_W'(SECTOR_UNITS);
  assign s5_yc_nxt = (Y_W'(s4_dif_r) + (Y_W'(s4_chroma_r) << 1)) * Y_W'(SECTOR_UNITS);
  assign s5_yx_nxt = s5_yz_nxt + (Y_W'(s4_prod_r) << 1);

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_yc_r     <= s5_yc_nxt;
      s5_yx_r     <= s5_yx_nxt;
      s5_yz_r     <= s5_yz_nxt;
      s5_sector_r <= s4_sector_r;
      s5_alpha_r  <= s4_alpha_r;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // Scale to 8 bits, route by sector into the output register
  logic [CHAN_W-1:0] chan_c, chan_x, chan_z;
  logic [CHAN_W-1:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;
  arrange_t          arr;

  hsl2rgb_scale u_scale_c (.level(s5_yc_r), .chan(chan_c));
  hsl2rgb_scale u_scale_x (.level(s5_yx_r), .chan(chan_x));
  hsl2rgb_scale u_scale_z (.level(s5_yz_r), .chan(chan_z));

  assign arr = sector_arrange(s5_sector_r);

  always_ff @(posedge clk) begin
    if (rdy6) begin
      out_red_r   <= pick(arr.red, chan_c, chan_x, chan_z);
      out_green_r <= pick(arr.green, chan_c, chan_x, chan_z);
      out_blue_r  <= pick(arr.blue, chan_c, chan_x, chan_z);
      out_alpha_r <= s5_alpha_r;
    end
  end

  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_alpha_out = out_alpha_r;

endmodule

// File: src/hsl2rgb_checker.sv
`include "hsl_to_rgb_converter_assert.svh"

// Port-level checks for the converter.
module hsl2rgb_checker
  import hsl2rgb_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [CHAN_W-1:0]        out_red,
  input logic [CHAN_W-1:0]        out_green,
  input logic [CHAN_W-1:0]        out_blue,
  input logic [CHAN_W-1:0]        out_alpha_out
);

  // A stalled result beat stays offered
  `HSL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped under stall")

  // A stalled result beat keeps its payload
  `HSL_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha_out), "result beat changed under stall")

  // Input backs up only when the whole pipe is full behind a stalled result
  `HSL_ASSERT(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with room in the pipe")

  // Reset empties the pipe
  `HSL_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result beat right after reset")

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_hsl2rgb_checker (.*);
